// ----- hdl/cone_search_radec_boxes_defines.svh -----
// assertion macros for the cone search box block
`ifndef CONE_SEARCH_RADEC_BOXES_DEFINES_SVH
`define CONE_SEARCH_RADEC_BOXES_DEFINES_SVH
`ifndef SYNTHESIS
`define CSRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csrb check failed");
`define CSRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csrb check failed");
`else
`define CSRB_ASSERT_IMP(lbl, ante, cons)
`define CSRB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/csrb_pkg.sv -----
// shared types and constants of the cone search box block
package csrb_pkg;
  localparam int FRAC_BITS = 16;
  localparam int RA_W    = 25;
  localparam int DEC_W   = 24;
  localparam int RAD_W   = 24;
  localparam int ANG_W   = 35;
  localparam int COS_W   = 31;
  localparam int COS_FRAC = 30;
  localparam int NUM_W   = RAD_W + COS_FRAC + 1;
  localparam logic [COS_W-1:0] COS_FLOOR = 31'd1073742;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // side information that travels with a request through the divider
  typedef struct packed {
    logic [ANG_W-1:0]        ra;
    logic signed [DEC_W-1:0] dlo;
    logic signed [DEC_W-1:0] dhi;
    logic                    sat;
  } ctx_t;
endpackage

// ----- hdl/csrb_cos_rom.sv -----
// quarter-wave cosine table with registered read
module csrb_cos_rom #(
  parameter int DEPTH = 1024,
  parameter int IW = 11
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [IW-1:0]             addr,
  output logic [csrb_pkg::COS_W-1:0] data
);
  import csrb_pkg::*;

  // truncated taylor series of cos, q1.30
  function automatic logic [COS_W-1:0] cos_entry(input longint unsigned i);
    longint unsigned x, x2, term;
    longint acc;
    x = i * HALF_PI_Q30 / DEPTH;
    x2 = (x * x) >> COS_FRAC;
    term = 64'd1 << COS_FRAC;
    acc = longint'(term);
    term = ((term * x2) >> COS_FRAC) / 2;   acc = acc - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 12;  acc = acc + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 30;  acc = acc - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 56;  acc = acc + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 90;  acc = acc - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 132; acc = acc + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 182; acc = acc - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 240; acc = acc + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 306; acc = acc - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 380; acc = acc + longint'(term);
    term = ((term * x2) >> COS_FRAC) / 462; acc = acc - longint'(term);
    term = ((term * x2) >> COS_FRAC) / 552; acc = acc + longint'(term);
    if (acc < 0) acc = 0;
    return COS_W'(acc);
  endfunction

  logic [COS_W-1:0] rom [0:DEPTH];

  // table contents fixed at elaboration
  for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
    localparam logic [COS_W-1:0] ENTRY = cos_entry(longint'(g));
    assign rom[g] = ENTRY;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end
endmodule

// ----- hdl/csrb_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module csrb_div #(
  parameter int QW = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_v,
  input  csrb_pkg::ctx_t               in_ctx,
  input  logic [csrb_pkg::NUM_W-1:0]   in_num,
  input  logic [csrb_pkg::COS_W-1:0]   in_den,
  output logic                         out_v,
  output csrb_pkg::ctx_t               out_ctx,
  output logic [QW-1:0]                out_q
);
  import csrb_pkg::*;

  logic             v   [0:QW];
  ctx_t             ctx [0:QW];
  logic [COS_W-1:0] rem [0:QW];
  logic [COS_W-1:0] den [0:QW];
  logic [QW-1:0]    low [0:QW];
  logic [QW-1:0]    q   [0:QW];

  // initial partial remainder is the numerator above the quotient bits
  assign v[0]   = in_v;
  assign ctx[0] = in_ctx;
  assign rem[0] = in_num[QW +: COS_W];
  assign den[0] = in_den;
  assign low[0] = in_num[QW-1:0];
  assign q[0]   = '0;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [COS_W:0] trial;
    logic           ge;
    assign trial = {rem[s], low[s][QW-1]};
    assign ge    = trial >= {1'b0, den[s]};

    // valid travels with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    // one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        ctx[s+1] <= ctx[s];
        den[s+1] <= den[s];
        low[s+1] <= {low[s][QW-2:0], 1'b0};
        q[s+1]   <= {q[s][QW-2:0], ge};
        rem[s+1] <= ge ? COS_W'(trial - {1'b0, den[s]}) : trial[COS_W-1:0];
      end
    end
  end

  assign out_v   = v[QW];
  assign out_ctx = ctx[QW];
  assign out_q   = q[QW];
endmodule

// ----- hdl/cone_search_radec_boxes.sv -----
// top level of the cone search ra/dec bounding box block
// Usage: a request (ra_center, dec_center, radius) enters on in_valid and is
// taken at a clock edge where in_stall is low. Each request yields one or two
// boxes on the out channel; last_box marks the final box of a request. A box
// is taken at an edge where out_valid is high and out_stall is low.
// Pipeline: five stages of input capture, range reduction and table index
// math, one table read, one stage for divisor setup and saturation,
// FRAC_BITS + 8 divider stages with one quotient bit each, and the output
// register.
// Throughput: a request can enter every cycle while in_stall is low; a request
// that splits into two boxes holds the output register until its second box
// has left, so the output port sets the rate at one box per cycle.
// Reset: synchronous, active high; clears all valid bits, the output valid
// and the pending second box.
// Stall: while a divider result waits on a stalled box or a pending second
// box, the whole pipeline freezes, in_stall rises; nothing is lost or repeated.
module cone_search_radec_boxes #(
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [csrb_pkg::RA_W-1:0]            ra_center,
  input  logic signed [csrb_pkg::DEC_W-1:0]    dec_center,
  input  logic [csrb_pkg::RAD_W-1:0]           radius,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [csrb_pkg::RA_W-1:0]            ra_low,
  output logic [csrb_pkg::RA_W-1:0]            ra_high,
  output logic signed [csrb_pkg::DEC_W-1:0]    dec_low,
  output logic signed [csrb_pkg::DEC_W-1:0]    dec_high,
  output logic                                 last_box
);
  import csrb_pkg::*;
  `include "cone_search_radec_boxes_defines.svh"

  localparam longint D90  = longint'(90) << FRAC_BITS;
  localparam longint D180 = longint'(180) << FRAC_BITS;
  localparam longint D360 = longint'(360) << FRAC_BITS;
  localparam longint INV180 = ((longint'(1) << 32) + D180 - 1) / D180;
  localparam longint INV360 = ((longint'(1) << 32) + D360 - 1) / D360;
  localparam longint INV90  = ((longint'(1) << 24) + 89) / 90;
  localparam int QW = FRAC_BITS + 8;
  localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int MW = 21;

  logic en;

  // stage 1: input registers
  logic                    v1;
  logic [RA_W-1:0]         s1_ra;
  logic signed [DEC_W-1:0] s1_dec;
  logic [RAD_W-1:0]        s1_rad;

  // stage 2: reciprocal quotient estimates
  logic                    v2;
  logic [RA_W-1:0]         s2_ra;
  logic [DEC_W-1:0]        s2_a;
  logic signed [DEC_W-1:0] s2_dec;
  logic [RAD_W-1:0]        s2_rad;
  logic [RA_W:0]           s2_qr;
  logic [DEC_W:0]          s2_qa;

  // stage 3: reduced angles and dec bounds
  logic                    v3;
  logic [ANG_W-1:0]        s3_ra;
  logic [ANG_W-1:0]        s3_af;
  logic [RAD_W-1:0]        s3_rad;
  logic signed [DEC_W-1:0] s3_dlo, s3_dhi;

  // stage 4: scaled folded angle
  logic                    v4;
  logic [ANG_W-1:0]        s4_ra;
  logic [RAD_W-1:0]        s4_rad;
  logic signed [DEC_W-1:0] s4_dlo, s4_dhi;
  logic [MW-1:0]           s4_m;

  // stage 5: index estimate
  logic                    v5;
  logic [ANG_W-1:0]        s5_ra;
  logic [RAD_W-1:0]        s5_rad;
  logic signed [DEC_W-1:0] s5_dlo, s5_dhi;
  logic [MW-1:0]           s5_m;
  logic [MW-1:0]           s5_q;

  // stage 6: table read
  logic                    v6;
  logic [ANG_W-1:0]        s6_ra;
  logic [RAD_W-1:0]        s6_rad;
  logic signed [DEC_W-1:0] s6_dlo, s6_dhi;
  logic [COS_W-1:0]        s6_cos;

  // stage 7: divider operands
  logic                    v7;
  ctx_t                    s7_ctx;
  logic [NUM_W-1:0]        s7_num;
  logic [COS_W-1:0]        s7_den;

  // divider tail and output
  logic             dv;
  ctx_t             dctx;
  logic [QW-1:0]    dq;
  logic             pend;
  logic [RA_W-1:0]  b1_lo, b1_hi;

  // pipeline moves unless a divider result waits on a box that cannot leave or a pending second box
  assign en = !(dv && out_valid && (out_stall || pend));
  assign in_stall = !en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ra  <= ra_center;
      s1_dec <= dec_center;
      s1_rad <= radius;
    end
  end

  // stage 2: abs dec and reciprocal estimates of the wrap counts
  logic [DEC_W-1:0] abs_dec;
  logic [63:0]      pr_ra, pr_a;
  always_comb begin
    abs_dec = s1_dec[DEC_W-1] ? DEC_W'(-s1_dec) : DEC_W'(s1_dec);
    pr_ra = 64'(s1_ra) * 64'(INV360);
    pr_a  = 64'(abs_dec) * 64'(INV180);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ra  <= s1_ra;
      s2_a   <= abs_dec;
      s2_dec <= s1_dec;
      s2_rad <= s1_rad;
      s2_qr  <= pr_ra[32 +: RA_W + 1];
      s2_qa  <= pr_a[32 +: DEC_W + 1];
    end
  end

  // stage 3: remainders with one correction, dec bounds clamped
  longint ra_m, a_m, dlo_w, dhi_w;
  always_comb begin
    ra_m = longint'(s2_ra) - longint'(s2_qr) * D360;
    if (ra_m < 0) ra_m = ra_m + D360;
    a_m = longint'(s2_a) - longint'(s2_qa) * D180;
    if (a_m < 0) a_m = a_m + D180;
    dlo_w = longint'(s2_dec) - longint'(s2_rad);
    dhi_w = longint'(s2_dec) + longint'(s2_rad);
    if (dlo_w < -D90) dlo_w = -D90;
    if (dlo_w > D90) dlo_w = D90;
    if (dhi_w < -D90) dhi_w = -D90;
    if (dhi_w > D90) dhi_w = D90;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ra  <= ANG_W'(ra_m);
      s3_af  <= ANG_W'(a_m);
      s3_rad <= s2_rad;
      s3_dlo <= DEC_W'(dlo_w);
      s3_dhi <= DEC_W'(dhi_w);
    end
  end

  // stage 4: fold into [0, 90] and scale to table steps
  longint fold, nscl;
  always_comb begin
    fold = longint'(s3_af);
    if (fold > D90) fold = D180 - fold;
    nscl = (fold * COS_TABLE_DEPTH + D90 / 2) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ra  <= s3_ra;
      s4_rad <= s3_rad;
      s4_dlo <= s3_dlo;
      s4_dhi <= s3_dhi;
      s4_m   <= MW'(nscl);
    end
  end

  // stage 5: divide by ninety through a reciprocal
  logic [63:0] pr_m;
  assign pr_m = 64'(s4_m) * 64'(INV90);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ra  <= s4_ra;
      s5_rad <= s4_rad;
      s5_dlo <= s4_dlo;
      s5_dhi <= s4_dhi;
      s5_m   <= s4_m;
      s5_q   <= pr_m[24 +: MW];
    end
  end

  // correct the estimate and clamp to the table end
  logic [MW+7:0] q90;
  logic [MW-1:0] qc;
  logic [IW-1:0] idx;
  always_comb begin
    q90 = (MW + 8)'(s5_q) * (MW + 8)'(90);
    qc = (q90 > (MW + 8)'(s5_m)) ? s5_q - 1'b1 : s5_q;
    idx = (qc > MW'(COS_TABLE_DEPTH)) ? IW'(COS_TABLE_DEPTH) : qc[IW-1:0];
  end

  // stage 6: table read
  csrb_cos_rom #(.DEPTH(COS_TABLE_DEPTH), .IW(IW)) u_rom (
    .clk  (clk),
    .en   (en),
    .addr (idx),
    .data (s6_cos)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ra  <= s5_ra;
      s6_rad <= s5_rad;
      s6_dlo <= s5_dlo;
      s6_dhi <= s5_dhi;
    end
  end

  // stage 7: floor the cosine, rounded numerator, saturation test
  logic [COS_W-1:0] cf;
  logic [NUM_W-1:0] num;
  logic [63:0]      sat_prod;
  always_comb begin
    cf = (s6_cos < COS_FLOOR) ? COS_FLOOR : s6_cos;
    num = (NUM_W'(s6_rad) << COS_FRAC) + NUM_W'(cf >> 1);
    sat_prod = 64'(D180) * 64'(cf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_ctx.ra  <= s6_ra;
      s7_ctx.dlo <= s6_dlo;
      s7_ctx.dhi <= s6_dhi;
      s7_ctx.sat <= 64'(num) >= sat_prod;
      s7_num <= num;
      s7_den <= cf;
    end
  end

  // half-width division
  csrb_div #(.QW(QW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (v7),
    .in_ctx  (s7_ctx),
    .in_num  (s7_num),
    .in_den  (s7_den),
    .out_v   (dv),
    .out_ctx (dctx),
    .out_q   (dq)
  );

  // box bounds from the half-width
  longint lo_w, hi_w;
  always_comb begin
    lo_w = longint'(dctx.ra) - longint'(dq);
    hi_w = longint'(dctx.ra) + longint'(dq);
  end

  // output register, second box of a split request waits in b1
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (out_valid && !out_stall && pend) begin
        ra_low   <= b1_lo;
        ra_high  <= b1_hi;
        last_box <= 1'b1;
        pend     <= 1'b0;
      end
      if (dv && en) begin
        out_valid <= 1'b1;
        dec_low   <= dctx.dlo;
        dec_high  <= dctx.dhi;
        b1_lo     <= '0;
        priority if (dctx.sat) begin
          ra_low   <= '0;
          ra_high  <= RA_W'(D360);
          last_box <= 1'b1;
          pend     <= 1'b0;
        end else if (lo_w < 0) begin
          ra_low   <= RA_W'(lo_w + D360);
          ra_high  <= RA_W'(D360);
          b1_hi    <= RA_W'(hi_w);
          last_box <= 1'b0;
          pend     <= 1'b1;
        end else if (hi_w > D360) begin
          ra_low   <= RA_W'(lo_w);
          ra_high  <= RA_W'(D360);
          b1_hi    <= RA_W'(hi_w - D360);
          last_box <= 1'b0;
          pend     <= 1'b1;
        end else begin
          ra_low   <= RA_W'(lo_w);
          ra_high  <= RA_W'(hi_w);
          last_box <= 1'b1;
          pend     <= 1'b0;
        end
      end else if (out_valid && !out_stall && !pend) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `CSRB_ASSERT_IMP(a_pend_shown, pend, out_valid && !last_box)
  `CSRB_ASSERT_NEXT(a_second_box, out_valid && !out_stall && !last_box, out_valid && last_box)
  `CSRB_ASSERT_NEXT(a_tail_holds, dv && !en, dv)
endmodule
